/* rtl/gdf_pkg.sv */
// ----------------------------------------------------------------------------
// gdf_pkg
// Shared types, constants and the exponential table of the dressing factor.
// ----------------------------------------------------------------------------
package gdf_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned ExpBits    = 24;

  localparam logic       CmdLoad = 1'b0;
  localparam logic       CmdEval = 1'b1;
  localparam logic [15:0] MarkerNegOne = 16'hFF00;
  localparam logic [15:0] InvFreqReset = 16'd256;
  localparam logic [33:0] FlushLimit   = 34'd5 << 16;
  localparam logic [32:0] AccOne       = 33'd1 << 32;
  localparam logic        RegInvFreq   = 1'b0;

  typedef struct packed {
    logic        command;
    logic [5:0]  index_p;
    logic [5:0]  index_q;
    logic [5:0]  index_r;
    logic [5:0]  index_s;
    logic signed [15:0] shift_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] factor;
    logic        two_term_form;
  } out_item_t;

  // Payload of one stage of the exponential chain.
  typedef struct packed {
    logic        cmd;
    logic        two;
    logic        flush;
    logic [23:0] y20;
    logic [32:0] acc;
  } exp_t;

  typedef logic [ExpBits-1:0][31:0] rom_t;

  // exp(-2^(b-20)) in Q32 by a truncated integer Taylor series in Q50.
  function automatic logic [31:0] rom_entry(input int unsigned b);
    logic [63:0] term;
    longint      sum;
    logic [63:0] res;
    term = 64'd1 << 50;
    sum  = longint'(term);
    for (int unsigned n = 1; n < 64; n++) begin
      if (b < 20) begin
        term = term >> (20 - b);
      end else begin
        term = term << (b - 20);
      end
      term = term / 64'(n);
      if (n[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    res = (64'(sum) + (64'd1 << 17)) >> 18;
    return res[31:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int unsigned b = 0; b < ExpBits; b++) begin
      r[b] = rom_entry(b);
    end
    return r;
  endfunction

  localparam rom_t ExpRom = build_rom();

endpackage

/* rtl/gdf_ram.sv */
// ----------------------------------------------------------------------------
// gdf_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module gdf_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read ports, held while not enabled.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

/* rtl/gdf_exp_stage.sv */
// ----------------------------------------------------------------------------
// gdf_exp_stage
// One bit of the exponential product: scales the accumulator when its bit is set.
// ----------------------------------------------------------------------------
module gdf_exp_stage (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [4:0]   idx_i,
  input  gdf_pkg::exp_t d_i,
  output gdf_pkg::exp_t q_o
);

  logic [31:0]   coef;
  logic [64:0]   prod;
  gdf_pkg::exp_t q_d;

  // Multiply by the table entry and round back to Q32.
  always_comb begin
    coef = gdf_pkg::ExpRom[idx_i];
    prod = 65'(d_i.acc) * 65'(coef) + (65'd1 << 31);
    q_d  = d_i;
    if (d_i.y20[idx_i]) begin
      q_d.acc = prod[64:32];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_o <= q_d;
    end
  end

endmodule

/* rtl/gaussian_dressing_factor_core.sv */
// ----------------------------------------------------------------------------
// gaussian_dressing_factor_core
// Shift table in two mirrored RAMs and a pipelined Gaussian factor datapath.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while out_ready_i is high; each pipeline stage moves on its own ready.
// The table RAMs give four reads a cycle; the 24 exponent stages set the depth.
// Reset clears the stage valid bits and sets inverse_frequency to 256.
// Table entries stay undefined until loaded.
module gaussian_dressing_factor_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gdf_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output gdf_pkg::out_item_t  out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned NumStg = 29;
  localparam int unsigned ExpFirst = 4;

  logic [NumStg:1] vld_q, vld_d, en;
  logic [15:0]     inv_q;
  logic            accept;

  // Configuration register.
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= gdf_pkg::InvFreqReset;
    end else if (psel && penable && pwrite && (paddr[2] == gdf_pkg::RegInvFreq)) begin
      inv_q <= pwdata[15:0];
    end
  end
  assign prdata = (paddr[2] == gdf_pkg::RegInvFreq) ? {16'd0, inv_q} : 32'd0;

  // Stage enables: a stage loads when empty or when the next one moves.
  always_comb begin
    en[NumStg] = !vld_q[NumStg] || out_ready_i;
    for (int k = NumStg - 1; k >= 1; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end
  assign in_ready_o = en[1];
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    vld_d = vld_q;
    if (en[1]) begin
      vld_d[1] = in_valid_i;
    end
    for (int k = 2; k <= NumStg; k++) begin
      if (en[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Stage 1: table reads, one mirror for p and q, the other for r and s.
  logic        we;
  logic [15:0] ep, eq, er, es;
  logic        cmd1_q;
  assign we = accept && (in_data_i.command == gdf_pkg::CmdLoad);

  gdf_ram #(.Width(16), .Depth(gdf_pkg::TableDepth)) u_ram_pq (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (in_data_i.index_p[gdf_pkg::AddrW-1:0]),
    .wdata_i  (in_data_i.shift_value),
    .re_i     (en[1]),
    .raddr_a_i(in_data_i.index_p[gdf_pkg::AddrW-1:0]),
    .raddr_b_i(in_data_i.index_q[gdf_pkg::AddrW-1:0]),
    .rdata_a_o(ep),
    .rdata_b_o(eq)
  );

  gdf_ram #(.Width(16), .Depth(gdf_pkg::TableDepth)) u_ram_rs (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (in_data_i.index_p[gdf_pkg::AddrW-1:0]),
    .wdata_i  (in_data_i.shift_value),
    .re_i     (en[1]),
    .raddr_a_i(in_data_i.index_r[gdf_pkg::AddrW-1:0]),
    .raddr_b_i(in_data_i.index_s[gdf_pkg::AddrW-1:0]),
    .rdata_a_o(er),
    .rdata_b_o(es)
  );

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      cmd1_q <= in_data_i.command;
    end
  end

  // Stage 2: difference of shifts and its magnitude.
  logic               two_d, cmd2_q, two2_q;
  logic signed [17:0] diff;
  logic [17:0]        mag_d, mag2_q;
  always_comb begin
    two_d = (cmd1_q == gdf_pkg::CmdEval) &&
            ((er == gdf_pkg::MarkerNegOne) || (es == gdf_pkg::MarkerNegOne));
    if (two_d) begin
      diff = 18'(signed'(ep)) - 18'(signed'(eq));
    end else begin
      diff = 18'(signed'(ep)) + 18'(signed'(er)) - 18'(signed'(es)) - 18'(signed'(eq));
    end
    mag_d = diff[17] ? 18'(-diff) : 18'(diff);
  end
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      cmd2_q <= cmd1_q;
      two2_q <= two_d;
      mag2_q <= mag_d;
    end
  end

  // Stage 3: scale by the inverse frequency.
  logic        cmd3_q, two3_q;
  logic [33:0] t3_q;
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      cmd3_q <= cmd2_q;
      two3_q <= two2_q;
      t3_q   <= 34'(mag2_q) * 34'(inv_q);
    end
  end

  // Stage 4: flush test and half square in Q20.
  gdf_pkg::exp_t       s4_d;
  gdf_pkg::exp_t       s4_q;
  logic [37:0]         sq;
  always_comb begin
    sq         = 38'(t3_q[18:0]) * 38'(t3_q[18:0]) + 38'd4096;
    s4_d.cmd   = cmd3_q;
    s4_d.two   = two3_q;
    s4_d.flush = (t3_q >= gdf_pkg::FlushLimit);
    s4_d.y20   = (s4_d.flush || (cmd3_q == gdf_pkg::CmdLoad)) ? 24'd0 : sq[36:13];
    s4_d.acc   = gdf_pkg::AccOne;
  end
  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s4_q <= s4_d;
    end
  end

  // Stages 5 to 28: one exponent bit each.
  gdf_pkg::exp_t chain [gdf_pkg::ExpBits+1];
  assign chain[0] = s4_q;
  for (genvar b = 0; b < gdf_pkg::ExpBits; b++) begin : g_exp
    gdf_exp_stage u_stage (
      .clk_i(clk_i),
      .en_i (en[ExpFirst+1+b]),
      .idx_i(5'(b)),
      .d_i  (chain[b]),
      .q_o  (chain[b+1])
    );
  end

  // Stage 29: rounding to Q0.16 with saturation, held until taken.
  gdf_pkg::exp_t       fin;
  logic [32:0]         rnd;
  gdf_pkg::out_item_t  out_d, out_q;
  always_comb begin
    fin = chain[gdf_pkg::ExpBits];
    rnd = fin.acc + 33'd32768;
    out_d.two_term_form = fin.two;
    if ((fin.cmd == gdf_pkg::CmdLoad) || fin.flush) begin
      out_d.factor = 16'd0;
    end else if (rnd[32:16] > 17'd65535) begin
      out_d.factor = 16'hFFFF;
    end else begin
      out_d.factor = rnd[31:16];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en[NumStg]) begin
      out_q <= out_d;
    end
  end
  assign out_valid_o = vld_q[NumStg];
  assign out_data_o  = out_q;

  // A stalled read stage keeps its table data.
  a_rd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] && !en[1] |=> $stable(ep) && $stable(er) && $stable(eq) && $stable(es))
    else $error("read stage lost its data while stalled");

  // Loads and flushed items leave the exponent chain untouched.
  a_acc_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NumStg-1] && (fin.flush || (fin.cmd == gdf_pkg::CmdLoad)) |-> fin.acc == gdf_pkg::AccOne)
    else $error("accumulator changed for a load or flushed item");

  // A load never reports the two-index form.
  a_load_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] && (cmd2_q == gdf_pkg::CmdLoad) |-> !two2_q)
    else $error("two-index flag set on a load item");

endmodule
